>>> sv/sbfr_pkg.sv
// Package with constants and controller/datapath interface types for the frame receiver.
`timescale 1ns / 1ps

package sbfr_pkg;

  localparam int FRAME_BYTES  = 25;
  localparam int STORE_DEPTH  = FRAME_BYTES - 2;
  localparam int STORE_BITS   = STORE_DEPTH * 8;
  localparam int CHAN_BITS    = 11;
  localparam int NUM_CHANNELS = 16;
  localparam int IDX_BITS     = 4;
  localparam int FILL_BITS    = 5;
  localparam int TICK_BITS    = 16;
  localparam int FS_BIT       = 2;
  localparam int LOST_BIT     = 3;

  localparam logic [7:0]           SYNC_BYTE     = 8'h0F;
  localparam logic [7:0]           END_BYTE      = 8'h00;
  localparam logic [TICK_BITS-1:0] TIMEOUT_RESET = 16'd10;
  localparam logic                 DROP_RESET    = 1'b1;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_DROP_FS = 1'b1;

  typedef struct packed {
    logic start;
    logic tick;
    logic store;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_sync;
    logic at_end;
    logic end_ok;
    logic fs_drop;
    logic tick_expire;
    logic emit_last;
  } sts_t;

endpackage

>>> sv/sbfr_datapath.sv
// Datapath: configuration registers, frame shift register, counters and result fields.
`timescale 1ns / 1ps

module sbfr_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [15:0]                cfg_wdata,
  input  logic [7:0]                 in_byte,
  input  sbfr_pkg::cmd_t             cmd,
  output sbfr_pkg::sts_t             sts,
  output logic [15:0]                out_tdata,
  output logic [1:0]                 out_tuser,
  output logic                       out_tlast
);

  logic [sbfr_pkg::TICK_BITS-1:0]  timeout_r;
  logic                            drop_r;
  logic [sbfr_pkg::STORE_BITS-1:0] data_r, data_nxt;
  logic [sbfr_pkg::FILL_BITS-1:0]  fill_r, fill_nxt;
  logic [sbfr_pkg::TICK_BITS-1:0]  elapsed_r, elapsed_nxt;
  logic [sbfr_pkg::IDX_BITS-1:0]   emit_idx_r, emit_idx_nxt;
  logic                            fs_r, fs_nxt;
  logic                            lf_r, lf_nxt;
  logic [sbfr_pkg::TICK_BITS-1:0]  elapsed_inc;
  logic [7:0]                      flag_byte;

  assign elapsed_inc = elapsed_r + sbfr_pkg::TICK_BITS'(1);
  assign flag_byte   = data_r[sbfr_pkg::STORE_BITS-1 -: 8];

  always_comb begin
    sts.is_sync     = (in_byte == sbfr_pkg::SYNC_BYTE);
    sts.at_end      = (fill_r == sbfr_pkg::FILL_BITS'(sbfr_pkg::FRAME_BYTES - 1));
    sts.end_ok      = (in_byte == sbfr_pkg::END_BYTE);
    sts.fs_drop     = flag_byte[sbfr_pkg::FS_BIT] & drop_r;
    sts.tick_expire = (elapsed_inc >= timeout_r);
    sts.emit_last   = (emit_idx_r == sbfr_pkg::IDX_BITS'(sbfr_pkg::NUM_CHANNELS - 1));
  end

  always_comb begin
    data_nxt     = data_r;
    fill_nxt     = fill_r;
    elapsed_nxt  = elapsed_r;
    emit_idx_nxt = emit_idx_r;
    fs_nxt       = fs_r;
    lf_nxt       = lf_r;
    if (cmd.start) begin
      fill_nxt    = sbfr_pkg::FILL_BITS'(1);
      elapsed_nxt = '0;
    end
    if (cmd.tick) begin
      elapsed_nxt = sts.tick_expire ? '0 : elapsed_inc;
    end
    if (cmd.store) begin
      data_nxt = {in_byte, data_r[sbfr_pkg::STORE_BITS-1:8]};
      fill_nxt = fill_r + sbfr_pkg::FILL_BITS'(1);
    end
    if (cmd.finish) begin
      elapsed_nxt  = '0;
      emit_idx_nxt = '0;
      fs_nxt       = flag_byte[sbfr_pkg::FS_BIT];
      lf_nxt       = flag_byte[sbfr_pkg::LOST_BIT];
    end
    if (cmd.emit) begin
      data_nxt     = data_r >> sbfr_pkg::CHAN_BITS;
      emit_idx_nxt = emit_idx_r + sbfr_pkg::IDX_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= sbfr_pkg::TIMEOUT_RESET;
      drop_r     <= sbfr_pkg::DROP_RESET;
      fill_r     <= '0;
      elapsed_r  <= '0;
      emit_idx_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sbfr_pkg::REG_TIMEOUT: timeout_r <= cfg_wdata;
          sbfr_pkg::REG_DROP_FS: drop_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
      fill_r     <= fill_nxt;
      elapsed_r  <= elapsed_nxt;
      emit_idx_r <= emit_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    fs_r   <= fs_nxt;
    lf_r   <= lf_nxt;
  end

  assign out_tdata = {1'b0, data_r[sbfr_pkg::CHAN_BITS-1:0], emit_idx_r};
  assign out_tuser = {lf_r, fs_r};
  assign out_tlast = sts.emit_last;

endmodule

>>> sv/sbfr_ctrl.sv
// Controller state machine: header hunt, frame collection and channel emission.
`timescale 1ns / 1ps

module sbfr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_tuser,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  sbfr_pkg::sts_t sts,
  output sbfr_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {S_HUNT, S_COLLECT, S_EMIT} state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   acc;

  assign acc = in_tvalid & in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_HUNT: begin
        if (acc && in_tuser == sbfr_pkg::OP_BYTE && sts.is_sync) begin
          cmd.start = 1'b1;
          state_nxt = S_COLLECT;
        end
      end
      S_COLLECT: begin
        if (acc && in_tuser == sbfr_pkg::OP_TICK) begin
          cmd.tick = 1'b1;
          if (sts.tick_expire) begin
            state_nxt = S_HUNT;
          end
        end else if (acc) begin
          if (!sts.at_end) begin
            cmd.store = 1'b1;
          end else begin
            cmd.finish = 1'b1;
            state_nxt  = (sts.end_ok && !sts.fs_drop) ? S_EMIT : S_HUNT;
          end
        end
      end
      S_EMIT: begin
        if (out_tready) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_HUNT;
          end
        end
      end
      default: state_nxt = S_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_HUNT;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= (state_nxt != S_EMIT);
      out_valid_r <= (state_nxt == S_EMIT);
    end
  end

  assign in_tready  = in_ready_r;
  assign out_tvalid = out_valid_r;

endmodule

>>> sv/sbus_frame_receiver.sv
// Top level of the 16-channel, 11-bit radio-control frame receiver.
// The input stream carries one item per transfer: in_tuser selects a received
// byte (0) or one timer tick (1), and in_tdata holds the byte.
// Bytes are ignored until a 0x0F header; the next 24 bytes complete a frame.
// A frame is dropped when its ticks reach the limit, when its end byte is not 0x00,
// or when its failsafe flag is set while dropping of such frames is enabled.
// A good frame gives 16 result transfers, channels 0 to 15 in order, with
// tlast on channel 15. Each channel is shifted out of a 184-bit frame register.
// After the end byte of a good frame the first result is valid on the next cycle,
// and one result leaves per cycle while out_tready is high.
// Input is not accepted while results are pending.
// When the receiver stalls, the current result holds and input stays blocked.
// Configuration writes via cfg_we take effect on the next cycle. The user must
// make them only while the block is idle; the block itself does not enforce it.
// Reset restores a tick limit of 10 with failsafe dropping enabled and
// returns the block to header hunting.
`timescale 1ns / 1ps

module sbus_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] channel_index, [14:4] channel_value
  output logic [1:0]  out_tuser,  // [0] failsafe, [1] frame_lost
  output logic        out_tlast
);

  sbfr_pkg::cmd_t cmd;
  sbfr_pkg::sts_t sts;

  sbfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sbfr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_byte   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

>>> verif/tb_sbus_frame_receiver.sv
// Self-checking testbench for the radio-control frame receiver with a built-in channel predictor.
`timescale 1ns / 1ps

module tb_sbus_frame_receiver;

  localparam int DRAIN_GAP   = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int SEG_ITEMS   = 20;

  typedef struct packed {
    logic [sbfr_pkg::IDX_BITS-1:0]  index;
    logic [sbfr_pkg::CHAN_BITS-1:0] value;
    logic                           fs;
    logic                           lost;
    logic                           last;
  } chan_t;

  class sbus_channel_predictor;
    logic [sbfr_pkg::TICK_BITS-1:0] timeout_lim;
    logic                           drop_fs;
    logic [sbfr_pkg::FILL_BITS-1:0] fill;
    logic [7:0]                     store [sbfr_pkg::STORE_DEPTH];
    logic [sbfr_pkg::TICK_BITS-1:0] ticks_seen;
    chan_t                          pending_channels[$];
    int                             mismatches;

    function void restart();
      timeout_lim = sbfr_pkg::TIMEOUT_RESET;
      drop_fs = sbfr_pkg::DROP_RESET;
      fill = '0;
      ticks_seen = '0;
      mismatches = 0;
      pending_channels.delete();
    endfunction

    function void set_register(logic idx, logic [15:0] v);
      if (idx == sbfr_pkg::REG_TIMEOUT) begin
        timeout_lim = v;
      end else begin
        drop_fs = v[0];
      end
    endfunction

    function void absorb_item(logic op, logic [7:0] b);
      logic [7:0]                      flags;
      logic [sbfr_pkg::STORE_BITS-1:0] bits;
      chan_t                           c;
      if (op == sbfr_pkg::OP_TICK) begin
        if (fill != 0) begin
          ticks_seen++;
          if (ticks_seen >= timeout_lim) begin
            fill = '0;
            ticks_seen = '0;
          end
        end
        return;
      end
      if (fill == 0) begin
        if (b == sbfr_pkg::SYNC_BYTE) begin
          fill = sbfr_pkg::FILL_BITS'(1);
          ticks_seen = '0;
        end
        return;
      end
      if (fill < sbfr_pkg::FRAME_BYTES - 1) begin
        store[fill - 1] = b;
        fill++;
        return;
      end
      fill = '0;
      ticks_seen = '0;
      if (b != sbfr_pkg::END_BYTE) return;
      flags = store[sbfr_pkg::STORE_DEPTH - 1];
      if (flags[sbfr_pkg::FS_BIT] && drop_fs) return;
      for (int i = 0; i < sbfr_pkg::STORE_DEPTH; i++) bits[i*8 +: 8] = store[i];
      for (int ch = 0; ch < sbfr_pkg::NUM_CHANNELS; ch++) begin
        c.index = sbfr_pkg::IDX_BITS'(ch);
        c.value = bits[ch*sbfr_pkg::CHAN_BITS +: sbfr_pkg::CHAN_BITS];
        c.fs = flags[sbfr_pkg::FS_BIT];
        c.lost = flags[sbfr_pkg::LOST_BIT];
        c.last = (ch == sbfr_pkg::NUM_CHANNELS - 1);
        pending_channels.push_back(c);
      end
    endfunction

    function void check_channel(logic [15:0] d, logic [1:0] u, logic l);
      chan_t e;
      if (pending_channels.size() == 0) begin
        $error("unexpected result: channel_index %0d channel_value %0d", d[3:0], d[14:4]);
        mismatches++;
        return;
      end
      e = pending_channels.pop_front();
      if (d[3:0] !== e.index) begin
        $error("channel_index: expected %0d, actual %0d", e.index, d[3:0]);
        mismatches++;
      end
      if (d[14:4] !== e.value) begin
        $error("channel_value: expected %0d, actual %0d", e.value, d[14:4]);
        mismatches++;
      end
      if (u[0] !== e.fs) begin
        $error("failsafe: expected %0d, actual %0d", e.fs, u[0]);
        mismatches++;
      end
      if (u[1] !== e.lost) begin
        $error("frame_lost: expected %0d, actual %0d", e.lost, u[1]);
        mismatches++;
      end
      if (l !== e.last) begin
        $error("last_channel: expected %0d, actual %0d", e.last, l);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  sbus_channel_predictor scb;
  logic [7:0] payload [22];
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int frame_items = 0;
  int hold_req_cnt = 0;

  sbus_frame_receiver dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    int stall_left;
    int hold_seen;
    stall_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) scb.check_channel(out_tdata, out_tuser, out_tlast);
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scb.absorb_item(op, b);
  endtask

  // Ticks are spread over the frame and always land before the end byte.
  task automatic send_frame(input logic [7:0] flags, input logic [7:0] endb, input int n_ticks);
    int left;
    left = n_ticks;
    send_item(sbfr_pkg::OP_BYTE, sbfr_pkg::SYNC_BYTE);
    for (int k = 0; k < 24; k++) begin
      while (left > 0 && (k == 23 || $urandom_range(0, 3) == 0)) begin
        send_item(sbfr_pkg::OP_TICK, 8'($urandom));
        left--;
      end
      send_item(sbfr_pkg::OP_BYTE, (k < 22) ? payload[k] : ((k == 22) ? flags : endb));
    end
    frame_items += 25 + n_ticks;
  endtask

  task automatic send_cut_frame(input int n_bytes, input int n_ticks);
    send_item(sbfr_pkg::OP_BYTE, sbfr_pkg::SYNC_BYTE);
    repeat (n_bytes) send_item(sbfr_pkg::OP_BYTE, 8'($urandom));
    repeat (n_ticks) send_item(sbfr_pkg::OP_TICK, 8'($urandom));
    frame_items += 1 + n_bytes + n_ticks;
  endtask

  task automatic randomize_payload();
    for (int i = 0; i < 22; i++) begin
      payload[i] = ($urandom_range(0, 15) == 0) ? sbfr_pkg::SYNC_BYTE : 8'($urandom);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (scb.pending_channels.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    scb.set_register(idx, v);
  endtask

  task automatic run_segment();
    int seg_start;
    int pick;
    int tmax;
    logic [15:0] lim;
    logic [7:0] flags;
    logic [7:0] endb;
    wait_drained();
    pick = $urandom_range(0, 3);
    lim = (pick == 0) ? 16'd1 : ((pick == 1) ? 16'hFFFF : 16'($urandom_range(2, 40)));
    cfg_write(sbfr_pkg::REG_TIMEOUT, lim);
    cfg_write(sbfr_pkg::REG_DROP_FS, 16'($urandom_range(0, 1)));
    tmax = (lim > 7) ? 6 : int'(lim) - 1;
    seg_start = frame_items;
    while (frame_items - seg_start < SEG_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        randomize_payload();
        flags = 8'($urandom);
        flags[sbfr_pkg::FS_BIT] = ($urandom_range(0, 3) == 0);
        endb = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : sbfr_pkg::END_BYTE;
        send_frame(flags, endb, $urandom_range(0, tmax));
      end else if (pick < 85 && lim <= 40) begin
        send_cut_frame($urandom_range(0, 20), lim);
      end else begin
        repeat ($urandom_range(2, 6)) send_item(1'($urandom_range(0, 1)), 8'($urandom));
      end
    end
  endtask

  initial begin
    scb = new;
    scb.restart();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct = 17;
    out_idle_pct = 73;

    // Ticks and stray bytes while hunting do nothing.
    send_item(sbfr_pkg::OP_TICK, 8'hA5);
    send_item(sbfr_pkg::OP_BYTE, 8'hFF);
    send_item(sbfr_pkg::OP_BYTE, 8'h00);
    // Full-scale channels with lost frame set, one tick short of the limit.
    for (int i = 0; i < 22; i++) payload[i] = 8'hFF;
    send_frame(8'h08, sbfr_pkg::END_BYTE, 9);
    // Header bytes inside the frame are plain data.
    randomize_payload();
    payload[0] = sbfr_pkg::SYNC_BYTE;
    payload[11] = sbfr_pkg::SYNC_BYTE;
    payload[21] = sbfr_pkg::SYNC_BYTE;
    send_frame(8'hF3, sbfr_pkg::END_BYTE, 2);
    randomize_payload();
    send_frame(8'h00, 8'h80, 0);
    send_frame(8'h04, sbfr_pkg::END_BYTE, 0);
    send_cut_frame(3, 10);

    wait_drained();
    cfg_write(sbfr_pkg::REG_DROP_FS, 16'd0);
    cfg_write(sbfr_pkg::REG_TIMEOUT, 16'd1);
    randomize_payload();
    send_frame(8'hFF, sbfr_pkg::END_BYTE, 0);
    send_cut_frame(0, 1);
    wait_drained();
    cfg_write(sbfr_pkg::REG_TIMEOUT, 16'hFFFF);
    randomize_payload();
    send_frame(8'h04, sbfr_pkg::END_BYTE, 12);

    frame_items = 0;
    in_idle_pct = 73;
    out_idle_pct = 17;
    run_segment();

    in_idle_pct = 0;
    out_idle_pct = 0;
    wait_drained();
    hold_req_cnt++;
    randomize_payload();
    send_frame(8'h00, sbfr_pkg::END_BYTE, 0);
    randomize_payload();
    send_frame(8'h08, sbfr_pkg::END_BYTE, 0);
    run_segment();

    wait_drained();
    if (scb.pending_channels.size() != 0) begin
      $error("%0d expected results never arrived", scb.pending_channels.size());
      scb.mismatches++;
    end
    if (scb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
